[src/ack_range_encoder_assert.svh]
// ----------------------------------------------------------------------------
// ack_range_encoder_assert.svh
// Assertion macros for the acknowledge range encoder.
// ----------------------------------------------------------------------------
`ifndef ACK_RANGE_ENCODER_ASSERT_SVH
`define ACK_RANGE_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property holds at every rising clock edge outside reset.
`define ACE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ack_range_encoder: assertion failed");

// Condition must never be seen outside reset.
`define ACE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("ack_range_encoder: forbidden condition seen");

`else

`define ACE_ASSERT(lbl, clk, rst_n, prop)
`define ACE_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[src/ace_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ace_pkg
// Shared types and constants of the acknowledge range encoder.
// ----------------------------------------------------------------------------
package ace_pkg;

	localparam int SEQ_W    = 24;
	localparam int ID_W     = 8;
	localparam int COUNT_W  = 16;
	localparam int LEN_W    = 19;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
	localparam logic [LEN_W-1:0]   BASE_LENGTH  = LEN_W'(3);
	localparam logic [LEN_W-1:0]   SINGLE_BYTES = LEN_W'(4);
	localparam logic [LEN_W-1:0]   RANGE_BYTES  = LEN_W'(7);

	localparam logic MODE_SEQ = 1'b0;
	localparam logic MODE_EOB = 1'b1;

	// register index (address bit 2 of the byte address)
	localparam logic REG_PACKET_ID = 1'b0;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_SINGLE  = 2'd0,
		KIND_RANGE   = 2'd1,
		KIND_TRAILER = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [SEQ_W-1:0]   first_num;
		logic [SEQ_W-1:0]   last_num;
		logic [ID_W-1:0]    id_byte;
		logic [COUNT_W-1:0] record_count;
		logic [LEN_W-1:0]   byte_length;
		logic               count_overflow;
		logic               last;
	} result_t;

	// up to two results per item, written in order
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic              room_for_two;
	} fifo_status_t;

endpackage
`default_nettype wire

[src/ace_run_tracker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ace_run_tracker
// Run merging, record booking and trailer forming for one item per cycle while fire is high.
// ----------------------------------------------------------------------------
module ace_run_tracker import ace_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire logic            mode,
	input  wire logic [SEQ_W-1:0] seq,
	input  wire logic [ID_W-1:0] packet_id,
	output push_t                push,
	output logic                 run_open
);

	logic               open_q, open_d;
	logic [SEQ_W-1:0]   first_q, first_d;
	logic [SEQ_W-1:0]   last_q, last_d;
	logic [COUNT_W-1:0] rec_q, rec_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic               ovf_q, ovf_d;

	logic               single;
	logic [COUNT_W-1:0] rec_b;
	logic [LEN_W-1:0]   len_b;
	logic               ovf_b;
	result_t            rec_res;
	result_t            trl_cur;
	result_t            trl_book;

	// what the counters become if the open run is booked now
	always_comb begin
		single = (first_q == last_q);
		if (rec_q != COUNT_MAX) begin
			rec_b = rec_q + COUNT_W'(1);
			len_b = len_q + (single ? SINGLE_BYTES : RANGE_BYTES);
			ovf_b = ovf_q;
		end else begin
			rec_b = rec_q;
			len_b = len_q;
			ovf_b = 1'b1;
		end
	end

	always_comb begin
		rec_res           = '0;
		rec_res.kind      = single ? KIND_SINGLE : KIND_RANGE;
		rec_res.first_num = first_q;
		rec_res.last_num  = last_q;

		trl_cur                = '0;
		trl_cur.kind           = KIND_TRAILER;
		trl_cur.id_byte        = packet_id;
		trl_cur.record_count   = rec_q;
		trl_cur.byte_length    = len_q;
		trl_cur.count_overflow = ovf_q;
		trl_cur.last           = 1'b1;

		trl_book                = trl_cur;
		trl_book.record_count   = rec_b;
		trl_book.byte_length    = len_b;
		trl_book.count_overflow = ovf_b;
	end

	always_comb begin
		open_d  = open_q;
		first_d = first_q;
		last_d  = last_q;
		rec_d   = rec_q;
		len_d   = len_q;
		ovf_d   = ovf_q;
		push    = '0;
		if (fire) begin
			if (mode == MODE_SEQ) begin
				if (!open_q) begin
					open_d  = 1'b1;
					first_d = seq;
					last_d  = seq;
				end else if (seq > last_q) begin
					if (seq == last_q + SEQ_W'(1)) begin
						last_d = seq;
					end else begin
						// gap closes the run
						push.num     = 2'd1;
						push.r0      = rec_res;
						push.r0.last = 1'b1;
						rec_d        = rec_b;
						len_d        = len_b;
						ovf_d        = ovf_b;
						first_d      = seq;
						last_d       = seq;
					end
				end
			end else begin
				if (open_q) begin
					push.num = 2'd2;
					push.r0  = rec_res;
					push.r1  = trl_book;
				end else begin
					push.num = 2'd1;
					push.r0  = trl_cur;
				end
				open_d  = 1'b0;
				first_d = '0;
				last_d  = '0;
				rec_d   = '0;
				len_d   = BASE_LENGTH;
				ovf_d   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			first_q <= '0;
			last_q  <= '0;
			rec_q   <= '0;
			len_q   <= BASE_LENGTH;
			ovf_q   <= 1'b0;
		end else begin
			open_q  <= open_d;
			first_q <= first_d;
			last_q  <= last_d;
			rec_q   <= rec_d;
			len_q   <= len_d;
			ovf_q   <= ovf_d;
		end
	end

	assign run_open = open_q;

endmodule
`default_nettype wire

[src/ace_out_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ace_out_fifo
// Small result queue taking up to two results a cycle and giving one when popped.
// ----------------------------------------------------------------------------
module ace_out_fifo import ace_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	input  wire logic  pop,
	output result_t    head,
	output logic       not_empty,
	output fifo_status_t status
);

	result_t           entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [PTR_W-1:0]  wr_ptr_1;
	logic              do_pop;

	assign wr_ptr_1 = wr_ptr_q + PTR_W'(1);
	assign do_pop   = pop && (fill_q != '0);

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			entry_q[wr_ptr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			entry_q[wr_ptr_1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.num);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_q + FILL_W'(push.num) - FILL_W'(do_pop);
		end
	end

	assign head                = entry_q[rd_ptr_q];
	assign not_empty           = (fill_q != '0);
	assign status.fill         = fill_q;
	assign status.room_for_two = (fill_q <= FILL_W'(FIFO_DEPTH - 2));

endmodule
`default_nettype wire

[src/ack_range_encoder.sv]
// ACK range encoder. Takes ascending 24-bit sequence numbers, one per item,
// merges consecutive ones into runs and emits a single or range record when
// a gap ends a run; an end-of-batch item flushes the open run and emits a
// trailer with packet id, record count and byte length. One item is taken
// per cycle unless the input stalls: an input register feeds a single pass
// of compare-and-update logic that writes its results into a four-entry
// result queue. Results leave one per cycle while result_stall is low. An
// end-of-batch item with an open run gives two results, but the first run
// of a batch is opened by a number item that gives none, so items run back
// to back while results are taken every cycle; the input stalls only when
// the queue has fewer than two free entries.
// packet_id lives at byte address 0 of the APB port.
`default_nettype none
// ----------------------------------------------------------------------------
// ack_range_encoder
// Top level: input register, run tracker, result queue and register port.
// ----------------------------------------------------------------------------
`include "ack_range_encoder_assert.svh"

module ack_range_encoder import ace_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input items
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic               mode,
	input  wire logic [SEQ_W-1:0]   seq_num,
	// results
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [1:0]              kind,
	output logic [SEQ_W-1:0]        first_num,
	output logic [SEQ_W-1:0]        last_num,
	output logic [ID_W-1:0]         id_byte,
	output logic [COUNT_W-1:0]      record_count,
	output logic [LEN_W-1:0]        byte_length,
	output logic                    count_overflow,
	output logic                    last,
	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready
);

	logic               valid_s1;
	logic               mode_s1;
	logic [SEQ_W-1:0]   seq_s1;
	logic [ID_W-1:0]    packet_id_q;
	logic               accept;
	logic               fire;
	logic               run_open;
	push_t              push;
	result_t            head;
	fifo_status_t       fifo_status;

	// register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_id_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_PACKET_ID) begin
			packet_id_q <= pwdata[ID_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PACKET_ID) begin
			prdata[ID_W-1:0] = packet_id_q;
		end
	end

	// input register; an item moves on only when the queue can take two results
	assign fire       = valid_s1 && fifo_status.room_for_two;
	assign item_stall = valid_s1 && !fifo_status.room_for_two;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			seq_s1  <= seq_num;
		end
	end

	ace_run_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.mode      (mode_s1),
		.seq       (seq_s1),
		.packet_id (packet_id_q),
		.push      (push),
		.run_open  (run_open)
	);

	ace_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (result_valid && !result_stall),
		.head      (head),
		.not_empty (result_valid),
		.status    (fifo_status)
	);

	assign kind           = head.kind;
	assign first_num      = head.first_num;
	assign last_num       = head.last_num;
	assign id_byte        = head.id_byte;
	assign record_count   = head.record_count;
	assign byte_length    = head.byte_length;
	assign count_overflow = head.count_overflow;
	assign last           = head.last;

	`ACE_ASSERT_NEVER(a_fifo_fill, clk, arst_n, fifo_status.fill > FILL_W'(FIFO_DEPTH))
	`ACE_ASSERT(a_eob_closes_run, clk, arst_n, (fire && mode_s1 == MODE_EOB) |=> !run_open)
	`ACE_ASSERT(a_trailer_last, clk, arst_n, (result_valid && kind == KIND_TRAILER) |-> last)
	`ACE_ASSERT(a_single_same, clk, arst_n, (result_valid && kind == KIND_SINGLE) |-> (first_num == last_num))

endmodule
`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives ascending acknowledge numbers and end-of-batch items into the range
// encoder with random gaps and output stalls, predicts every record and
// trailer, and compares them field by field.
// ----------------------------------------------------------------------------
import ace_pkg::*;

class ack_record_tracker;
	logic [ID_W-1:0]    packet_id;
	bit                 run_open;
	logic [SEQ_W-1:0]   run_first;
	logic [SEQ_W-1:0]   run_last;
	logic [COUNT_W-1:0] n_records;
	logic [LEN_W-1:0]   n_bytes;
	bit                 saturated;
	result_t            due[$];
	int unsigned        errors;

	function new();
		packet_id = '0;
		errors = 0;
		clear_batch();
	endfunction

	function void clear_batch();
		run_open = 1'b0;
		run_first = '0;
		run_last = '0;
		n_records = '0;
		n_bytes = BASE_LENGTH;
		saturated = 1'b0;
	endfunction

	function void set_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		if (addr[ADDR_W-1:2] == REG_PACKET_ID)
			packet_id = data[ID_W-1:0];
	endfunction

	// queue the record of the open run and book it against the batch totals
	function void close_run(logic is_last);
		result_t r;
		bit single;
		single = (run_first == run_last);
		r = '0;
		r.kind = single ? KIND_SINGLE : KIND_RANGE;
		r.first_num = run_first;
		r.last_num = run_last;
		r.last = is_last;
		due = {due, r};
		if (n_records != COUNT_MAX) begin
			n_records++;
			n_bytes += single ? SINGLE_BYTES : RANGE_BYTES;
		end else begin
			saturated = 1'b1;
		end
	endfunction

	function void note_item(logic m, logic [SEQ_W-1:0] s);
		result_t t;
		if (m == MODE_SEQ) begin
			if (!run_open) begin
				run_open = 1'b1;
				run_first = s;
				run_last = s;
			end else if (s > run_last) begin
				if (s == run_last + 1) begin
					run_last = s;
				end else begin
					close_run(1'b1);
					run_first = s;
					run_last = s;
				end
			end
		end else begin
			if (run_open)
				close_run(1'b0);
			t = '0;
			t.kind = KIND_TRAILER;
			t.id_byte = packet_id;
			t.record_count = n_records;
			t.byte_length = n_bytes;
			t.count_overflow = saturated;
			t.last = 1'b1;
			due = {due, t};
			clear_batch();
		end
	endfunction

	function void compare(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endfunction

	function void check_record(result_t got);
		result_t want;
		if (due.size() == 0) begin
			$error("result with nothing expected: kind %0d first %0d",
				got.kind, got.first_num);
			errors++;
			return;
		end
		want = due.pop_front();
		compare("kind", 32'(want.kind), 32'(got.kind));
		compare("first_num", 32'(want.first_num), 32'(got.first_num));
		compare("last_num", 32'(want.last_num), 32'(got.last_num));
		compare("id_byte", 32'(want.id_byte), 32'(got.id_byte));
		compare("record_count", 32'(want.record_count), 32'(got.record_count));
		compare("byte_length", 32'(want.byte_length), 32'(got.byte_length));
		compare("count_overflow", 32'(want.count_overflow), 32'(got.count_overflow));
		compare("last", 32'(want.last), 32'(got.last));
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT       = 1_000_000;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 200;
	localparam logic [ADDR_W-1:0] ADDR_PACKET_ID = {REG_PACKET_ID, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_UNMAPPED  = {~REG_PACKET_ID, 2'b00};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               mode = MODE_SEQ;
	logic [SEQ_W-1:0]   seq_num = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [1:0]         kind;
	logic [SEQ_W-1:0]   first_num;
	logic [SEQ_W-1:0]   last_num;
	logic [ID_W-1:0]    id_byte;
	logic [COUNT_W-1:0] record_count;
	logic [LEN_W-1:0]   byte_length;
	logic               count_overflow;
	logic               last;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	ack_record_tracker trk = new();
	bit tx_calm = 1'b0;
	bit hold_req = 1'b0;
	int cycle_count = 0;

	ack_range_encoder dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.mode(mode), .seq_num(seq_num),
		.result_valid(result_valid), .result_stall(result_stall),
		.kind(kind), .first_num(first_num), .last_num(last_num),
		.id_byte(id_byte), .record_count(record_count), .byte_length(byte_length),
		.count_overflow(count_overflow), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (tx_calm)
			return 0;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// APB setup then access; a read is checked against the predicted id
	task automatic apb_cycle(input bit wr, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr) begin
			trk.set_reg(a, d);
		end else if (prdata !== DATA_W'(trk.packet_id)) begin
			$error("prdata: expected %0h, got %0h", trk.packet_id, prdata);
			trk.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_item(input logic m, input logic [SEQ_W-1:0] s);
		int unsigned g;
		item_valid <= 1'b1;
		mode <= m;
		seq_num <= s;
		do @(posedge clk); while (item_stall);
		trk.note_item(m, s);
		g = pick_gap();
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (trk.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// batches of ascending numbers with random steps, plus repeats, smaller
	// numbers, noise and early end-of-batch items
	task automatic random_items(input int count, input int hold_at, input int pause_at);
		int done;
		int batch_left;
		int unsigned r;
		longint nxt;
		logic [SEQ_W-1:0] top;
		logic [SEQ_W-1:0] s;
		bit fresh;
		bit counted;
		done = 0;
		batch_left = 0;
		top = '0;
		fresh = 1'b1;
		while (done < count) begin
			if (done % 100 == 0)
				tx_calm = ($urandom_range(3) == 0);
			if (done == hold_at) begin
				hold_req = 1'b1;
				hold_at = -1;
			end
			if (done == pause_at) begin
				drain();
				pause_at = -1;
			end
			counted = 1'b1;
			r = $urandom_range(99);
			if (batch_left == 0 || r < 2) begin
				send_item(MODE_EOB, SEQ_W'($urandom));
				r = $urandom_range(99);
				batch_left = (r < 8) ? 0 : (r < 90) ? $urandom_range(1, 12)
					: $urandom_range(13, 60);
				r = $urandom_range(99);
				top = (r < 50) ? SEQ_W'($urandom_range(0, 1000))
					: (r < 80) ? SEQ_W'($urandom)
					: SEQ_W'(24'hFFFFFF - $urandom_range(0, 200));
				fresh = 1'b1;
			end else begin
				r = $urandom_range(99);
				if (fresh) begin
					nxt = longint'(top);
				end else if (r < 55) begin
					nxt = longint'(top) + 1;
				end else if (r < 78) begin
					nxt = longint'(top) + longint'($urandom_range(2, 9));
				end else if (r < 85) begin
					nxt = longint'(top) + longint'($urandom_range(10, 65536));
				end else if (r < 92) begin
					nxt = longint'(top);
					counted = 1'b0;
				end else if (r < 97) begin
					nxt = longint'(top) - longint'($urandom_range(1, 5));
					counted = 1'b0;
				end else begin
					nxt = longint'($urandom & 32'hFFFFFF);
				end
				if (nxt > 64'hFFFFFF)
					nxt = 64'hFFFFFF;
				if (nxt < 0)
					nxt = 0;
				s = SEQ_W'(nxt);
				send_item(MODE_SEQ, s);
				if (fresh || s > top)
					top = s;
				fresh = 1'b0;
				batch_left--;
			end
			if (counted)
				done++;
		end
	endtask

	initial begin
		int unsigned r;
		int busy_left;
		int free_left;
		int hold_left;
		result_t got;
		busy_left = 0;
		free_left = 0;
		hold_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				got = {kind, first_num, last_num, id_byte, record_count, byte_length,
					count_overflow, last};
				trk.check_record(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (busy_left > 0) begin
				busy_left--;
				result_stall <= 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				result_stall <= 1'b0;
			end else begin
				r = $urandom_range(99);
				free_left = (r < 10) ? $urandom_range(40, 120) : $urandom_range(0, 5);
				busy_left = (r >= 10 && r < 15) ? $urandom_range(10, 40)
					: (r >= 15 && r < 50) ? $urandom_range(1, 3) : 0;
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_cycle(1'b0, ADDR_PACKET_ID, '0);
		apb_cycle(1'b1, ADDR_PACKET_ID, 32'hFF);
		// no register behind this address: the id must not move
		apb_cycle(1'b1, ADDR_UNMAPPED, 32'h5A);
		apb_cycle(1'b0, ADDR_PACKET_ID, '0);

		// empty batch, repeats, smaller numbers, runs, gaps, range ends
		send_item(MODE_EOB, '0);
		send_item(MODE_SEQ, 24'd0);
		send_item(MODE_SEQ, 24'd0);
		send_item(MODE_SEQ, 24'd1);
		send_item(MODE_SEQ, 24'd0);
		send_item(MODE_SEQ, 24'd5);
		send_item(MODE_SEQ, 24'd7);
		send_item(MODE_EOB, 24'hFFFFFF);
		send_item(MODE_SEQ, 24'hFFFFFE);
		send_item(MODE_SEQ, 24'hFFFFFF);
		send_item(MODE_EOB, '0);
		send_item(MODE_SEQ, 24'hFFFFFF);
		send_item(MODE_SEQ, 24'hFFFFFF);
		send_item(MODE_EOB, 24'h000001);
		send_item(MODE_SEQ, 24'h800000);
		send_item(MODE_SEQ, 24'h7FFFFF);
		send_item(MODE_SEQ, 24'h800001);
		send_item(MODE_SEQ, 24'h800003);
		send_item(MODE_EOB, 24'h555555);
		send_item(MODE_EOB, 24'hAAAAAA);
		drain();

		apb_cycle(1'b1, ADDR_PACKET_ID, 32'h00);
		random_items(520, 300, -1);
		drain();

		apb_cycle(1'b1, ADDR_PACKET_ID, 32'h01);
		random_items(520, -1, 300);
		drain();

		apb_cycle(1'b1, ADDR_PACKET_ID, $urandom);
		apb_cycle(1'b0, ADDR_PACKET_ID, '0);
		random_items(480, -1, -1);
		drain();

		if (trk.errors == 0 && trk.due.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

[filelist.f]
+incdir+src
src/ace_pkg.sv
src/ace_run_tracker.sv
src/ace_out_fifo.sv
src/ack_range_encoder.sv
bench/testbench.sv
